@@ src/ecgqrs_pkg.sv @@
// Shared types, constants and helper functions of the ECG QRS beat detector.
`timescale 1ns / 1ps
`default_nettype none

package ecgqrs_pkg;

   // Defaults for the top-level parameters.
   localparam int SAMPLE_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF    = 16;

   // Field and state widths.
   localparam int CFG_W   = 16;
   localparam int RATE_W  = 12;
   localparam int LEVEL_W = 50;
   localparam int COUNT_W = 32;
   localparam int IVAL_W  = 16;
   localparam int HR_W    = 24;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};
   localparam logic [IVAL_W-1:0]  IVAL_MAX  = {IVAL_W{1'b1}};
   localparam logic [HR_W-1:0]    HR_MAX    = {HR_W{1'b1}};

   // Shared multiply-accumulate unit.
   localparam int MAC_OP_W   = 32;
   localparam int MAC_PROD_W = 2 * MAC_OP_W;
   localparam int MAC_ACC_W  = 68;
   localparam int COEF_W     = 16;
   localparam int COEF_SHIFT = 16;
   localparam logic [MAC_ACC_W-1:0] ROUND_BIAS = MAC_ACC_W'(1) << (COEF_SHIFT - 1);

   // Q16 smoothing coefficients, rounded to nearest.
   localparam logic [COEF_W-1:0] C_E_OLD = 16'd58982;
   localparam logic [COEF_W-1:0] C_E_NEW = 16'd6554;
   localparam logic [COEF_W-1:0] C_T_OLD = 16'd65208;
   localparam logic [COEF_W-1:0] C_T_NEW = 16'd983;

   // Rate divider: 60 * 256 * rate = (rate << 14) - (rate << 10).
   localparam int BPM_SHIFT_HI = 14;
   localparam int BPM_SHIFT_LO = 10;
   localparam int DIV_DVD_W    = 26;
   localparam int DIV_DVS_W    = 16;
   localparam int DIV_CNT_W    = $clog2(DIV_DVD_W);

   // Configuration port.
   localparam int APB_ADDR_W = 4;
   localparam int APB_DATA_W = 32;

   localparam logic [CFG_W-1:0]  REFRACTORY_RST = 16'd75;
   localparam logic [CFG_W-1:0]  MIN_IVAL_RST   = 16'd100;
   localparam logic [CFG_W-1:0]  MAX_IVAL_RST   = 16'd500;
   localparam logic [RATE_W-1:0] RATE_RST       = 12'd250;

   typedef enum logic [1:0] {
      REG_REFRACTORY  = 2'd0,
      REG_MIN_IVAL    = 2'd1,
      REG_MAX_IVAL    = 2'd2,
      REG_SAMPLE_RATE = 2'd3
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQR,
      ST_SQW,
      ST_E0,
      ST_E1,
      ST_E2,
      ST_E3,
      ST_EW,
      ST_T0,
      ST_T1,
      ST_T2,
      ST_T3,
      ST_TW,
      ST_DEC,
      ST_CMP,
      ST_DIV
   } st_type;

   typedef enum logic {
      OUT_IDLE,
      OUT_PENDING
   } out_type;

   typedef struct packed {
      logic valid;
      logic clear;
      logic bias;
      logic hi;
   } mac_cmd_type;

   // Drops the Q16 coefficient scale from an accumulator and saturates to a level.
   function automatic logic [LEVEL_W-1:0] level_from_acc(input logic [MAC_ACC_W-1:0] acc);
      logic [MAC_ACC_W-COEF_SHIFT-1:0] scaled;
      scaled = acc[MAC_ACC_W-1:COEF_SHIFT];
      if (|scaled[MAC_ACC_W-COEF_SHIFT-1:LEVEL_W]) begin
         return LEVEL_MAX;
      end
      return scaled[LEVEL_W-1:0];
   endfunction

endpackage

`default_nettype wire

@@ src/ecgqrs_mac.sv @@
// Shared multiply-accumulate unit: registered 32x32 product, then a wide accumulate.
`timescale 1ns / 1ps
`default_nettype none

module ecgqrs_mac (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire ecgqrs_pkg::mac_cmd_type              cmd,
   input  wire logic [ecgqrs_pkg::MAC_OP_W-1:0]      op_a,
   input  wire logic [ecgqrs_pkg::MAC_OP_W-1:0]      op_b,
   output logic      [ecgqrs_pkg::MAC_ACC_W-1:0]     acc
);

   localparam int OP_W   = ecgqrs_pkg::MAC_OP_W;
   localparam int PROD_W = ecgqrs_pkg::MAC_PROD_W;
   localparam int ACC_W  = ecgqrs_pkg::MAC_ACC_W;

   ecgqrs_pkg::mac_cmd_type cmd_ff;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic [ACC_W-1:0]        acc_ff, acc_in;
   logic [ACC_W-1:0]        addend;
   logic [ACC_W-1:0]        base;

   assign prod_in = op_a * op_b;

   always_comb begin
      // An upper-word product carries a weight of 2^32.
      if (cmd_ff.hi) begin
         addend = {prod_ff[ACC_W-OP_W-1:0], {OP_W{1'b0}}};
      end else begin
         addend = ACC_W'(prod_ff);
      end
      if (cmd_ff.clear) begin
         base = cmd_ff.bias ? ecgqrs_pkg::ROUND_BIAS : '0;
      end else begin
         base = acc_ff;
      end
      acc_in = cmd_ff.valid ? (base + addend) : acc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff <= '0;
      end else begin
         cmd_ff <= cmd;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;

endmodule

`default_nettype wire

@@ src/ecgqrs_div.sv @@
// Restoring divider, one quotient bit per cycle, for the heart rate.
`timescale 1ns / 1ps
`default_nettype none

module ecgqrs_div (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   input  wire logic [ecgqrs_pkg::DIV_DVD_W-1:0]     dividend,
   input  wire logic [ecgqrs_pkg::DIV_DVS_W-1:0]     divisor,
   output logic                                      done,
   output logic      [ecgqrs_pkg::DIV_DVD_W-1:0]     quotient
);

   localparam int DVD_W = ecgqrs_pkg::DIV_DVD_W;
   localparam int DVS_W = ecgqrs_pkg::DIV_DVS_W;
   localparam int CNT_W = ecgqrs_pkg::DIV_CNT_W;

   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [DVS_W:0]   shifted;
   logic [DVS_W:0]   diff;
   logic             fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[DVD_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      fits    = (shifted >= {1'b0, dvs_ff});

      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(DVD_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
         quo_in = {quo_ff[DVD_W-2:0], fits};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

`ifndef NO_ASSERTIONS
   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider reports done while still iterating");
`endif

endmodule

`default_nettype wire

@@ src/ecg_qrs_beat_detector.sv @@
// Top level of the ECG QRS beat detector: sequencer, state and configuration registers.
//
//   channel  | direction | handshake             | payload
//   req      | in        | req_valid / req_ready | req_sample
//   rsp      | out       | rsp_valid / rsp_ready | rsp_beat, rsp_interval_reported,
//            |           |                       | rsp_interval_samples, rsp_heart_rate_q8
//   csr      | in/out    | psel, penable, pready | paddr, pwrite, pwdata, prdata
//
// The first sample after reset only primes the differencer. Every later sample passes
// through the shared multiply-accumulate unit (square, energy and threshold blends), and
// through the bit-serial divider when an accepted interval needs a heart rate.
// req_ready is high only while the sequencer is idle and no finished beat is pending;
// one result register holds the finished beat until the output register is free, so a new
// sample is taken while rsp_valid waits once that beat has moved on. Reset is synchronous.
`timescale 1ns / 1ps
`default_nettype none

module ecg_qrs_beat_detector #(
   parameter int SAMPLE_WIDTH = ecgqrs_pkg::SAMPLE_WIDTH_DEF,
   parameter int FRAC_BITS    = ecgqrs_pkg::FRAC_BITS_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,

   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic signed [SAMPLE_WIDTH-1:0]        req_sample,

   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic                                       rsp_beat,
   output logic                                       rsp_interval_reported,
   output logic      [ecgqrs_pkg::IVAL_W-1:0]         rsp_interval_samples,
   output logic      [ecgqrs_pkg::HR_W-1:0]           rsp_heart_rate_q8,

   input  wire logic                                  psel,
   input  wire logic                                  penable,
   input  wire logic                                  pwrite,
   input  wire logic [ecgqrs_pkg::APB_ADDR_W-1:0]     paddr,
   input  wire logic [ecgqrs_pkg::APB_DATA_W-1:0]     pwdata,
   output logic      [ecgqrs_pkg::APB_DATA_W-1:0]     prdata,
   output logic                                       pready
);

   localparam int SW      = SAMPLE_WIDTH;
   localparam int LEVEL_W = ecgqrs_pkg::LEVEL_W;
   localparam int COUNT_W = ecgqrs_pkg::COUNT_W;
   localparam int IVAL_W  = ecgqrs_pkg::IVAL_W;
   localparam int HR_W    = ecgqrs_pkg::HR_W;
   localparam int CFG_W   = ecgqrs_pkg::CFG_W;
   localparam int RATE_W  = ecgqrs_pkg::RATE_W;
   localparam int OP_W    = ecgqrs_pkg::MAC_OP_W;
   localparam int ACC_W   = ecgqrs_pkg::MAC_ACC_W;
   localparam int DVD_W   = ecgqrs_pkg::DIV_DVD_W;
   localparam int DVS_W   = ecgqrs_pkg::DIV_DVS_W;
   localparam int DATA_W  = ecgqrs_pkg::APB_DATA_W;

   // Largest square that still fits a level once shifted into fixed point.
   localparam logic [LEVEL_W-1:0] SQ_LIMIT = ecgqrs_pkg::LEVEL_MAX >> FRAC_BITS;

   // Sequencer and state registers.
   ecgqrs_pkg::st_type  state_ff, state_in;
   ecgqrs_pkg::out_type pend_ff, pend_in;
   logic               started_ff, started_in;
   logic [SW-1:0]      prev_ff, prev_in;
   logic [SW-1:0]      mag_ff, mag_in;
   logic [LEVEL_W-1:0] sqq_ff, sqq_in;
   logic [LEVEL_W-1:0] energy_ff, energy_in;
   logic [LEVEL_W-1:0] thr_ff, thr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] peak_ff, peak_in;
   logic               peak_valid_ff, peak_valid_in;

   // Result being built, then the output register.
   logic               res_beat_ff, res_beat_in;
   logic               res_rep_ff, res_rep_in;
   logic [IVAL_W-1:0]  res_ival_ff, res_ival_in;
   logic [HR_W-1:0]    res_hr_ff, res_hr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_beat_ff, rsp_beat_in;
   logic               rsp_rep_ff, rsp_rep_in;
   logic [IVAL_W-1:0]  rsp_ival_ff, rsp_ival_in;
   logic [HR_W-1:0]    rsp_hr_ff, rsp_hr_in;

   // Configuration registers.
   logic [CFG_W-1:0]   refr_ff, refr_in;
   logic [CFG_W-1:0]   min_ival_ff, min_ival_in;
   logic [CFG_W-1:0]   max_ival_ff, max_ival_in;
   logic [RATE_W-1:0]  rate_ff, rate_in;

   // Shared unit and divider connections.
   ecgqrs_pkg::mac_cmd_type mac_cmd;
   logic [OP_W-1:0]    mac_a;
   logic [OP_W-1:0]    mac_b;
   logic [ACC_W-1:0]   mac_acc;
   logic               div_start;
   logic [DVD_W-1:0]   div_dividend;
   logic [DVS_W-1:0]   div_divisor;
   logic               div_done;
   logic [DVD_W-1:0]   div_quotient;

   // Combinational helpers.
   logic               req_fire;
   logic               rsp_free;
   logic               csr_write;
   ecgqrs_pkg::reg_index_type csr_index;
   logic [SW:0]        diff;
   logic [SW:0]        diff_abs;
   logic [ACC_W-1:0]   sq_shifted;
   logic [LEVEL_W-1:0] sq_level;
   logic [LEVEL_W-1:0] acc_level;
   logic [COUNT_W-1:0] elapsed;
   logic               above;
   logic               past_refr;
   logic               in_range;
   logic [HR_W-1:0]    hr_sat;

   ecgqrs_mac u_mac (
      .clock (clock),
      .reset (reset),
      .cmd   (mac_cmd),
      .op_a  (mac_a),
      .op_b  (mac_b),
      .acc   (mac_acc)
   );

   ecgqrs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign req_ready = (state_ff == ecgqrs_pkg::ST_IDLE) && (pend_ff == ecgqrs_pkg::OUT_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = ecgqrs_pkg::reg_index_type'(paddr[3:2]);
   assign pready    = 1'b1;

   always_comb begin
      case (csr_index)
         ecgqrs_pkg::REG_REFRACTORY:  prdata = DATA_W'(refr_ff);
         ecgqrs_pkg::REG_MIN_IVAL:    prdata = DATA_W'(min_ival_ff);
         ecgqrs_pkg::REG_MAX_IVAL:    prdata = DATA_W'(max_ival_ff);
         ecgqrs_pkg::REG_SAMPLE_RATE: prdata = DATA_W'(rate_ff);
         default:                     prdata = '0;
      endcase
   end

   always_comb begin
      refr_in     = refr_ff;
      min_ival_in = min_ival_ff;
      max_ival_in = max_ival_ff;
      rate_in     = rate_ff;
      if (csr_write) begin
         case (csr_index)
            ecgqrs_pkg::REG_REFRACTORY:  refr_in     = pwdata[CFG_W-1:0];
            ecgqrs_pkg::REG_MIN_IVAL:    min_ival_in = pwdata[CFG_W-1:0];
            ecgqrs_pkg::REG_MAX_IVAL:    max_ival_in = pwdata[CFG_W-1:0];
            ecgqrs_pkg::REG_SAMPLE_RATE: rate_in     = pwdata[RATE_W-1:0];
            default: ;
         endcase
      end
   end

   // Datapath pieces shared by several sequencer steps.
   always_comb begin
      diff       = {req_sample[SW-1], req_sample} - {prev_ff[SW-1], prev_ff};
      diff_abs   = diff[SW] ? (~diff + 1'b1) : diff;
      sq_shifted = mac_acc << FRAC_BITS;
      sq_level   = (mac_acc > ACC_W'(SQ_LIMIT)) ? ecgqrs_pkg::LEVEL_MAX
                                                : sq_shifted[LEVEL_W-1:0];
      acc_level  = ecgqrs_pkg::level_from_acc(mac_acc);
      elapsed    = count_ff - peak_ff;
      above      = (energy_ff > thr_ff);
      past_refr  = (elapsed >= COUNT_W'(refr_ff));
      in_range   = (elapsed >= COUNT_W'(min_ival_ff)) && (elapsed <= COUNT_W'(max_ival_ff));
      hr_sat     = (|div_quotient[DVD_W-1:HR_W]) ? ecgqrs_pkg::HR_MAX
                                                 : div_quotient[HR_W-1:0];
      div_dividend = DVD_W'({rate_ff, {ecgqrs_pkg::BPM_SHIFT_HI{1'b0}}})
                   - DVD_W'({rate_ff, {ecgqrs_pkg::BPM_SHIFT_LO{1'b0}}})
                   + DVD_W'(elapsed[IVAL_W-1:1]);
      div_divisor  = elapsed[DVS_W-1:0];
   end

   // Sequencer: next state, shared-unit commands and state updates.
   always_comb begin
      state_in      = state_ff;
      pend_in       = pend_ff;
      started_in    = started_ff;
      prev_in       = prev_ff;
      mag_in        = mag_ff;
      sqq_in        = sqq_ff;
      energy_in     = energy_ff;
      thr_in        = thr_ff;
      count_in      = count_ff;
      peak_in       = peak_ff;
      peak_valid_in = peak_valid_ff;
      res_beat_in   = res_beat_ff;
      res_rep_in    = res_rep_ff;
      res_ival_in   = res_ival_ff;
      res_hr_in     = res_hr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_beat_in   = rsp_beat_ff;
      rsp_rep_in    = rsp_rep_ff;
      rsp_ival_in   = rsp_ival_ff;
      rsp_hr_in     = rsp_hr_ff;
      mac_cmd       = '0;
      mac_a         = '0;
      mac_b         = '0;
      div_start     = 1'b0;

      case (state_ff)
         ecgqrs_pkg::ST_IDLE: begin
            if (req_fire) begin
               prev_in     = req_sample;
               res_beat_in = 1'b0;
               res_rep_in  = 1'b0;
               res_ival_in = '0;
               res_hr_in   = '0;
               if (!started_ff) begin
                  // The very first sample only primes the differencer.
                  started_in = 1'b1;
                  count_in   = count_ff + 1'b1;
                  pend_in    = ecgqrs_pkg::OUT_PENDING;
               end else begin
                  mag_in   = diff_abs[SW-1:0];
                  state_in = ecgqrs_pkg::ST_SQR;
               end
            end
         end
         ecgqrs_pkg::ST_SQR: begin
            mac_cmd  = '{valid: 1'b1, clear: 1'b1, bias: 1'b0, hi: 1'b0};
            mac_a    = OP_W'(mag_ff);
            mac_b    = OP_W'(mag_ff);
            state_in = ecgqrs_pkg::ST_SQW;
         end
         ecgqrs_pkg::ST_SQW: begin
            state_in = ecgqrs_pkg::ST_E0;
         end
         ecgqrs_pkg::ST_E0: begin
            sqq_in   = sq_level;
            mac_cmd  = '{valid: 1'b1, clear: 1'b1, bias: 1'b1, hi: 1'b0};
            mac_a    = energy_ff[OP_W-1:0];
            mac_b    = OP_W'(ecgqrs_pkg::C_E_OLD);
            state_in = ecgqrs_pkg::ST_E1;
         end
         ecgqrs_pkg::ST_E1: begin
            mac_cmd  = '{valid: 1'b1, clear: 1'b0, bias: 1'b0, hi: 1'b1};
            mac_a    = OP_W'(energy_ff[LEVEL_W-1:OP_W]);
            mac_b    = OP_W'(ecgqrs_pkg::C_E_OLD);
            state_in = ecgqrs_pkg::ST_E2;
         end
         ecgqrs_pkg::ST_E2: begin
            mac_cmd  = '{valid: 1'b1, clear: 1'b0, bias: 1'b0, hi: 1'b0};
            mac_a    = sqq_ff[OP_W-1:0];
            mac_b    = OP_W'(ecgqrs_pkg::C_E_NEW);
            state_in = ecgqrs_pkg::ST_E3;
         end
         ecgqrs_pkg::ST_E3: begin
            mac_cmd  = '{valid: 1'b1, clear: 1'b0, bias: 1'b0, hi: 1'b1};
            mac_a    = OP_W'(sqq_ff[LEVEL_W-1:OP_W]);
            mac_b    = OP_W'(ecgqrs_pkg::C_E_NEW);
            state_in = ecgqrs_pkg::ST_EW;
         end
         ecgqrs_pkg::ST_EW: begin
            state_in = ecgqrs_pkg::ST_T0;
         end
         ecgqrs_pkg::ST_T0: begin
            energy_in = acc_level;
            mac_cmd   = '{valid: 1'b1, clear: 1'b1, bias: 1'b1, hi: 1'b0};
            mac_a     = thr_ff[OP_W-1:0];
            mac_b     = OP_W'(ecgqrs_pkg::C_T_OLD);
            state_in  = ecgqrs_pkg::ST_T1;
         end
         ecgqrs_pkg::ST_T1: begin
            mac_cmd  = '{valid: 1'b1, clear: 1'b0, bias: 1'b0, hi: 1'b1};
            mac_a    = OP_W'(thr_ff[LEVEL_W-1:OP_W]);
            mac_b    = OP_W'(ecgqrs_pkg::C_T_OLD);
            state_in = ecgqrs_pkg::ST_T2;
         end
         ecgqrs_pkg::ST_T2: begin
            // The threshold follows the energy that was just updated.
            mac_cmd  = '{valid: 1'b1, clear: 1'b0, bias: 1'b0, hi: 1'b0};
            mac_a    = energy_ff[OP_W-1:0];
            mac_b    = OP_W'(ecgqrs_pkg::C_T_NEW);
            state_in = ecgqrs_pkg::ST_T3;
         end
         ecgqrs_pkg::ST_T3: begin
            mac_cmd  = '{valid: 1'b1, clear: 1'b0, bias: 1'b0, hi: 1'b1};
            mac_a    = OP_W'(energy_ff[LEVEL_W-1:OP_W]);
            mac_b    = OP_W'(ecgqrs_pkg::C_T_NEW);
            state_in = ecgqrs_pkg::ST_TW;
         end
         ecgqrs_pkg::ST_TW: begin
            state_in = ecgqrs_pkg::ST_DEC;
         end
         ecgqrs_pkg::ST_DEC: begin
            thr_in   = acc_level;
            count_in = count_ff + 1'b1;
            state_in = ecgqrs_pkg::ST_CMP;
         end
         ecgqrs_pkg::ST_CMP: begin
            state_in = ecgqrs_pkg::ST_IDLE;
            pend_in  = ecgqrs_pkg::OUT_PENDING;
            if (above && past_refr) begin
               if (!peak_valid_ff) begin
                  peak_in       = count_ff;
                  peak_valid_in = 1'b1;
               end else begin
                  res_rep_in  = 1'b1;
                  res_ival_in = (|elapsed[COUNT_W-1:IVAL_W]) ? ecgqrs_pkg::IVAL_MAX
                                                             : elapsed[IVAL_W-1:0];
                  // An interval outside the window leaves the peak where it was.
                  if (in_range) begin
                     res_beat_in = 1'b1;
                     peak_in     = count_ff;
                     if (elapsed == '0) begin
                        res_hr_in = ecgqrs_pkg::HR_MAX;
                     end else begin
                        div_start = 1'b1;
                        pend_in   = ecgqrs_pkg::OUT_IDLE;
                        state_in  = ecgqrs_pkg::ST_DIV;
                     end
                  end
               end
            end
         end
         ecgqrs_pkg::ST_DIV: begin
            if (div_done) begin
               res_hr_in = hr_sat;
               pend_in   = ecgqrs_pkg::OUT_PENDING;
               state_in  = ecgqrs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ecgqrs_pkg::ST_IDLE;
         end
      endcase

      // A finished beat moves to the output register once that register is free.
      if (pend_ff == ecgqrs_pkg::OUT_PENDING && rsp_free) begin
         pend_in      = ecgqrs_pkg::OUT_IDLE;
         rsp_valid_in = 1'b1;
         rsp_beat_in  = res_beat_ff;
         rsp_rep_in   = res_rep_ff;
         rsp_ival_in  = res_ival_ff;
         rsp_hr_in    = res_hr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ecgqrs_pkg::ST_IDLE;
         pend_ff       <= ecgqrs_pkg::OUT_IDLE;
      end else begin
         state_ff      <= state_in;
         pend_ff       <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff    <= 1'b0;
         prev_ff       <= '0;
         energy_ff     <= '0;
         thr_ff        <= '0;
         count_ff      <= '0;
         peak_ff       <= '0;
         peak_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         refr_ff       <= ecgqrs_pkg::REFRACTORY_RST;
         min_ival_ff   <= ecgqrs_pkg::MIN_IVAL_RST;
         max_ival_ff   <= ecgqrs_pkg::MAX_IVAL_RST;
         rate_ff       <= ecgqrs_pkg::RATE_RST;
      end else begin
         started_ff    <= started_in;
         prev_ff       <= prev_in;
         energy_ff     <= energy_in;
         thr_ff        <= thr_in;
         count_ff      <= count_in;
         peak_ff       <= peak_in;
         peak_valid_ff <= peak_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         refr_ff       <= refr_in;
         min_ival_ff   <= min_ival_in;
         max_ival_ff   <= max_ival_in;
         rate_ff       <= rate_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      sqq_ff      <= sqq_in;
      res_beat_ff <= res_beat_in;
      res_rep_ff  <= res_rep_in;
      res_ival_ff <= res_ival_in;
      res_hr_ff   <= res_hr_in;
      rsp_beat_ff <= rsp_beat_in;
      rsp_rep_ff  <= rsp_rep_in;
      rsp_ival_ff <= rsp_ival_in;
      rsp_hr_ff   <= rsp_hr_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_beat              = rsp_beat_ff;
   assign rsp_interval_reported = rsp_rep_ff;
   assign rsp_interval_samples  = rsp_ival_ff;
   assign rsp_heart_rate_q8     = rsp_hr_ff;

`ifndef NO_ASSERTIONS
   a_peak_stays_valid: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> !$fell(peak_valid_ff))
      else $error("peak marker was lost without a reset");

   a_beat_has_interval: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_beat) |-> rsp_interval_reported)
      else $error("beat flagged without a reported interval");

   a_rate_only_on_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_beat) |-> (rsp_heart_rate_q8 == '0))
      else $error("heart rate set on a result without a beat");

   a_energy_update_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ecgqrs_pkg::ST_T0) |=> $stable(energy_ff))
      else $error("energy changed outside its update step");

   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ecgqrs_pkg::ST_DIV))
      else $error("divider finished while the sequencer was not waiting for it");
`endif

endmodule

`default_nettype wire
